FILE: hw/rtl/tfdr_pkg.sv
`timescale 1ns / 1ps

package tfdr_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 8;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ACT_W  = 3;
    localparam int STAT_W = 3;

    localparam int IN_W  = ((ACT_W + ID_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_W = STAT_W + ID_BITS + CNT_W + 1;
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int POPPED_LSB = STAT_W;
    localparam int CNT_LSB    = STAT_W + ID_BITS;
    localparam int CLOSED_LSB = STAT_W + ID_BITS + CNT_W;

    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_OPEN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLOSE    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CLOSED   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/task_fifo_dedup_remove_core.sv
`timescale 1ns / 1ps
// ordered task queue with duplicate check and removal by identifier
// input stream: one beat per request, tdata = action, task_id (low bits first)
// output stream: one beat per request, tdata = status, popped_id, entry_count,
//   is_closed (low bits first)
// one request is handled at a time: s_axis_tready is high only while the
//   sequencer is idle
// entries live in a single-port-write, single-port-read ram; one shared
//   comparator walks them one entry per cycle, each read issued in the cycle before its compare
// close, pop on empty or closed queue and unknown actions: straight to the result
// append: duplicate search over all queued entries
// remove: search up to the hit, then move later entries up one
// pop: head read, then move the rest up one
// the result sits in an output register, so a stalled receiver holds the beat
//   and the next request is still taken; the sequencer waits only when a new
//   result is ready while the previous one has not been taken
// reset empties the queue and clears the closed flag; ram contents need no
//   clearing since only entries below the count are ever read
module task_fifo_dedup_remove_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tfdr_pkg::IN_W-1:0]   s_axis_tdata,   // action, task_id
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tfdr_pkg::OUT_W-1:0]  m_axis_tdata    // status, popped_id, entry_count, is_closed
);

    import tfdr_pkg::*;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   action_reg, action_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               closed_reg, closed_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cmp_ptr_reg, cmp_ptr_next;
    logic               pend_reg, pend_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [ID_BITS-1:0] popped_reg, popped_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic [ID_BITS-1:0] ram_rdata;
    logic               issue;
    logic               hit;
    logic [CNT_W-1:0]   wr_pos;
    logic [ACT_W-1:0]   in_action;

    tfdr_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign issue     = rd_ptr_reg < count_reg;
    assign hit       = pend_reg && (ram_rdata == id_reg);
    assign wr_pos    = cmp_ptr_reg - CNT_W'(1);
    assign in_action = s_axis_tdata[ACT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        id_reg       <= id_next;
        rd_ptr_reg   <= rd_ptr_next;
        cmp_ptr_reg  <= cmp_ptr_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        closed_next    = closed_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_pos[IDX_W-1:0];
        ram_wdata      = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next  = in_action;
                    id_next      = s_axis_tdata[ACT_W +: ID_BITS];
                    status_next  = STAT_OK;
                    popped_next  = '0;
                    rd_ptr_next  = '0;
                    cmp_ptr_next = '0;
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                    case (in_action)
                        ACT_APPEND, ACT_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        ACT_POP, ACT_POP_OPEN:
                        begin
                            if ((in_action == ACT_POP_OPEN) && closed_reg)
                            begin
                                status_next = STAT_CLOSED;
                            end
                            else if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_CLOSE:
                        begin
                            closed_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (action_reg == ACT_APPEND)
                    begin
                        status_next = STAT_DUP;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_ptr_next = cmp_ptr_reg + CNT_W'(1);
                        state_next  = S_SHIFT;
                    end
                end
                else if (!issue)
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    if (action_reg == ACT_APPEND)
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = id_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = STAT_NOTFOUND;
                    end
                end
                else
                begin
                    pend_next    = 1'b1;
                    cmp_ptr_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    if (cmp_ptr_reg == '0)
                    begin
                        popped_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                if (issue)
                begin
                    pend_next    = 1'b1;
                    cmp_ptr_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({closed_reg, count_reg, popped_reg, status_reg});
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/tfdr_ram.sv
`timescale 1ns / 1ps

module tfdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/tfdr_checker.sv
`timescale 1ns / 1ps

module tfdr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [tfdr_pkg::IN_W-1:0]   s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [tfdr_pkg::OUT_W-1:0]  m_axis_tdata
);

    import tfdr_pkg::*;

    logic [STAT_W-1:0]  out_status;
    logic [ID_BITS-1:0] out_popped;
    logic [CNT_W-1:0]   out_count;

    assign out_status = m_axis_tdata[STAT_W-1:0];
    assign out_popped = m_axis_tdata[POPPED_LSB +: ID_BITS];
    assign out_count  = m_axis_tdata[CNT_LSB +: CNT_W];

    // one request at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a request is still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_count <= CNT_W'(DEPTH)))
        else $error("entry count beyond queue depth");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_status != STAT_OK)) |-> (out_popped == '0))
        else $error("popped id set on a failed request");

    // idle and nothing offered: stays ready
    a_ready_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && !s_axis_tvalid) |=> s_axis_tready)
        else $error("input ready dropped without a beat");

endmodule

bind task_fifo_dedup_remove_core tfdr_checker u_tfdr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/tfdr_result_checker.sv
`timescale 1ns / 1ps

module tfdr_result_checker
    import tfdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_BITS-1:0] popped_id;
        logic [CNT_W-1:0]   entry_count;
        logic               is_closed;
    } result_t;

    logic [ID_BITS-1:0] task_list[$];
    logic               queue_closed;
    result_t            expected_results[$];

    function automatic result_t apply_request(input logic [ACT_W-1:0] act,
                                              input logic [ID_BITS-1:0] id);
        result_t r;
        int      pos;
        r = '0;
        r.status = STAT_OK;
        pos = -1;
        foreach (task_list[i])
        begin
            if (pos < 0 && task_list[i] == id)
                pos = i;
        end
        case (act)
            ACT_APPEND:
            begin
                if (pos >= 0)
                    r.status = STAT_DUP;
                else if (task_list.size() >= DEPTH)
                    r.status = STAT_FULL;
                else
                    task_list.push_back(id);
            end
            ACT_REMOVE:
            begin
                if (pos >= 0)
                    task_list.delete(pos);
                else
                    r.status = STAT_NOTFOUND;
            end
            ACT_POP, ACT_POP_OPEN:
            begin
                if (act == ACT_POP_OPEN && queue_closed)
                    r.status = STAT_CLOSED;
                else if (task_list.size() == 0)
                    r.status = STAT_EMPTY;
                else
                    r.popped_id = task_list.pop_front();
            end
            ACT_CLOSE:
                queue_closed = 1'b1;
            default:
                ;
        endcase
        r.entry_count = CNT_W'(task_list.size());
        r.is_closed = queue_closed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            task_list.delete();
            expected_results.delete();
            queue_closed = 1'b0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_request(s_axis_tdata[ACT_W-1:0],
                                                         s_axis_tdata[ACT_W +: ID_BITS]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status      = m_axis_tdata[STAT_W-1:0];
                got.popped_id   = m_axis_tdata[POPPED_LSB +: ID_BITS];
                got.entry_count = m_axis_tdata[CNT_LSB +: CNT_W];
                got.is_closed   = m_axis_tdata[CLOSED_LSB];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with none outstanding: status %0d id %0d count %0d closed %0d",
                                 $realtime, got.status, got.popped_id, got.entry_count,
                                 got.is_closed);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp status %0d id %0d count %0d closed %0d, got status %0d id %0d count %0d closed %0d",
                                     $realtime, want.status, want.popped_id, want.entry_count,
                                     want.is_closed, got.status, got.popped_id,
                                     got.entry_count, got.is_closed);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/task_fifo_dedup_remove_core_test.sv
`timescale 1ns / 1ps

module task_fifo_dedup_remove_core_test;

    import tfdr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
    localparam int PHASE_ITEMS  = 450;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   phase = 0;
    int   idle_cycles = 0;
    logic req_taken;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task_fifo_dedup_remove_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tfdr_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: long hold-off when the last phase starts, then per-phase idling
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase == 2 && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (phase == 0)
                m_axis_tready <= ($urandom_range(99) >= 85);
            else if (phase == 1)
                m_axis_tready <= ($urandom_range(99) >= 9);
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic offer_request(input logic [ACT_W-1:0] act, input logic [ID_BITS-1:0] id);
        int idle_pct;
        idle_pct = (phase == 0) ? 9 : ((phase == 1) ? 85 : 0);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - ACT_W - ID_BITS){1'b0}}, id, act};
        do
            @(negedge clk);
        while (!req_taken);
    endtask

    // alternating fill-heavy and drain-heavy stretches, ids mostly from a small pool
    task automatic run_random(input int count, input bit allow_close);
        int                 k;
        int                 r;
        bit                 filling;
        logic [ACT_W-1:0]   act;
        logic [ID_BITS-1:0] id;
        for (k = 0; k < count; k++)
        begin
            filling = ((k / 40) % 2) == 0;
            r = $urandom_range(99);
            if (r < (filling ? 60 : 25))
                act = ACT_APPEND;
            else if (r < (filling ? 72 : 50))
                act = ACT_REMOVE;
            else if (r < (filling ? 84 : 73))
                act = ACT_POP;
            else if (r < 96)
                act = ACT_POP_OPEN;
            else if (r < 98)
                act = allow_close ? ACT_CLOSE : ACT_REMOVE;
            else
                act = ACT_W'($urandom_range(7, 5));
            if ($urandom_range(99) < 80)
                id = ID_BITS'($urandom_range(23));
            else
                id = ID_BITS'($urandom_range(255));
            offer_request(act, id);
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer_request(ACT_POP, 8'd0);
        offer_request(ACT_POP_OPEN, 8'd0);
        offer_request(ACT_REMOVE, 8'd5);
        offer_request(ACT_APPEND, 8'd0);
        offer_request(ACT_APPEND, 8'd255);
        offer_request(ACT_APPEND, 8'd255);
        for (k = 1; k <= DEPTH - 2; k++)
            offer_request(ACT_APPEND, ID_BITS'(k));
        offer_request(ACT_APPEND, 8'd7);
        offer_request(ACT_APPEND, 8'd200);
        offer_request(ACT_REMOVE, 8'd7);
        offer_request(ACT_POP, 8'd0);
        offer_request(ACT_POP_OPEN, 8'd0);
        offer_request(ACT_W'(7), 8'd255);

        run_random(PHASE_ITEMS, 1'b0);
        phase = 1;
        run_random(PHASE_ITEMS, 1'b0);
        phase = 2;
        run_random(PHASE_ITEMS, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tfdr_pkg.sv
hw/rtl/tfdr_ram.sv
hw/rtl/task_fifo_dedup_remove_core.sv
hw/rtl/tfdr_checker.sv
tb/sv/tfdr_result_checker.sv
tb/sv/task_fifo_dedup_remove_core_test.sv
